// ===== src/pca_pkg.sv =====
// Shared constants and codes for the command priority array.
// No dependencies; every other file imports this package.
`default_nettype none

package pca_pkg;

    // sizing
    localparam int NUM_OUTPUTS    = 4;
    localparam int NUM_PRIORITIES = 16;
    localparam int INST_W         = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
    localparam int SLOT_W         = $clog2(NUM_PRIORITIES);
    localparam int MEM_DEPTH      = NUM_OUTPUTS * NUM_PRIORITIES;
    localparam int ADDR_W         = $clog2(MEM_DEPTH);

    // field widths
    localparam int CMD_W   = 3;
    localparam int REQI_W  = 22;
    localparam int PRIO_W  = 8;
    localparam int VAL_W   = 16;
    localparam int TAG_W   = 2;
    localparam int SIDX_W  = 8;
    localparam int ERR_W   = 3;
    localparam int LEVEL_W = 8;
    localparam int ALEN_W  = 5;

    // levels and limits
    localparam logic [LEVEL_W-1:0] LEVEL_NULL    = 8'd255;
    localparam logic [PRIO_W-1:0]  RESERVED_PRIO = 8'd6;
    localparam logic [VAL_W-1:0]   MAX_VALUE_Q8  = 16'd25600;

    // commands
    localparam logic [CMD_W-1:0] CMD_WRITE_VALUE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_OOS   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE_OTHER = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_PV     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_SLOT   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_ALL    = 3'd5;

    // value tags
    localparam logic [TAG_W-1:0] TAG_REAL  = 2'd0;
    localparam logic [TAG_W-1:0] TAG_NULL  = 2'd1;
    localparam logic [TAG_W-1:0] TAG_BOOL  = 2'd2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE    = 3'd0;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN = 3'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_DENIED  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TYPE    = 3'd4;
    localparam logic [ERR_W-1:0] ERR_INDEX   = 3'd5;

endpackage

`default_nettype wire

// ===== src/pca_ifs.sv =====
// Request and response channel interfaces (valid/ready plus payload).
// Depends on pca_pkg for field widths.
`default_nettype none

interface pca_req_if;
    import pca_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [REQI_W-1:0]        instance_req;
    logic [PRIO_W-1:0]        prio;
    logic signed [VAL_W-1:0]  value_q8;
    logic [TAG_W-1:0]         tag;
    logic                     bool_value;
    logic [SIDX_W-1:0]        slot_index;

    modport source (
        output valid, cmd, instance_req, prio, value_q8, tag, bool_value, slot_index,
        input  ready
    );
    modport sink (
        input  valid, cmd, instance_req, prio, value_q8, tag, bool_value, slot_index,
        output ready
    );
endinterface

interface pca_rsp_if;
    import pca_pkg::*;

    logic               valid;
    logic               ready;
    logic               ok;
    logic [ERR_W-1:0]   err;
    logic [LEVEL_W-1:0] level;
    logic               is_null;
    logic [ALEN_W-1:0]  array_length;
    logic               last;

    modport source (
        output valid, ok, err, level, is_null, array_length, last,
        input  ready
    );
    modport sink (
        input  valid, ok, err, level, is_null, array_length, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/priority_command_array.sv =====
// Command priority array top level: request decode, slot memory and sequencer.
// Depends on pca_pkg and the channel interfaces in pca_ifs.sv.
//
// Usage:
//   i_req carries one command beat (write value, write out-of-service, write
//   other, read present value, read one slot, read all slots). o_rsp returns
//   result beats; every request ends with a beat that has last set. A read-all
//   returns 16 beats, one per priority slot, last on the final one.
//   i_cfg_we/i_cfg_wdata load the relinquish default; write it only while idle.
// Timing:
//   One request is handled at a time; i_req.ready is high only while idle.
//   Writes and errors: the request is checked in the execute state and the result
//   beat registered; slot reads pass through the read state first. Present value:
//   the walk reads slots in turn from slot 1, stopping at the first non-null one or
//   the last. Read-all: each slot is read and its beat offered in turn. The single
//   compare/read path over the slot memory (one read port, registered data) sets this order.
// Reset: synchronous active-low; all slots read as null (valid bits clear),
//   out-of-service flags and relinquish default go to zero.
// Stall: a result beat is held in the output register until o_rsp.ready;
//   the walk pauses meanwhile.
`default_nettype none

module priority_command_array (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    pca_req_if.sink                              i_req,
    pca_rsp_if.source                            o_rsp,
    input  wire logic                            i_cfg_we,
    input  wire logic [pca_pkg::LEVEL_W-1:0]     i_cfg_wdata
);
    import pca_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_PRIORITIES - 1);

    // control state
    logic [1:0]             r_state, n_state;
    logic [SLOT_W-1:0]      r_slot, n_slot;
    logic [LEVEL_W-1:0]     r_relinq;
    logic [NUM_OUTPUTS-1:0] r_oos;
    logic [MEM_DEPTH-1:0]   r_mem_vld;
    logic                   r_rd_vld;

    // latched request
    logic [CMD_W-1:0]       r_cmd;
    logic                   r_inst_ok;
    logic [INST_W-1:0]      r_inst;
    logic [PRIO_W-1:0]      r_prio;
    logic [VAL_W-1:0]       r_val;
    logic [TAG_W-1:0]       r_tag;
    logic                   r_bv;
    logic [SIDX_W-1:0]      r_sidx;

    // result register
    logic                   r_ok, n_ok;
    logic [ERR_W-1:0]       r_err, n_err;
    logic [LEVEL_W-1:0]     r_level, n_level;
    logic                   r_null, n_null;
    logic [ALEN_W-1:0]      r_alen, n_alen;
    logic                   r_last, n_last;

    // slot memory
    logic [LEVEL_W-1:0]     mem [MEM_DEPTH];
    logic [LEVEL_W-1:0]     r_rd_data;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [LEVEL_W-1:0]     wr_data;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   oos_we;

    // request checks
    logic                   accept;
    logic                   prio_ok;
    logic                   real_ok;
    logic [LEVEL_W-1:0]     rd_level;
    logic                   rd_is_null;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign prio_ok = (r_prio >= PRIO_W'(1)) && (r_prio <= PRIO_W'(NUM_PRIORITIES));
    assign real_ok = prio_ok && (r_prio != RESERVED_PRIO) && !r_val[VAL_W-1]
                     && (r_val <= MAX_VALUE_Q8);

    // shared compare: the slot just read, null when never written
    assign rd_level   = r_rd_vld ? r_rd_data : LEVEL_NULL;
    assign rd_is_null = (rd_level == LEVEL_NULL);

    assign wr_addr = ADDR_W'({r_inst, SLOT_W'(r_prio - PRIO_W'(1))});
    assign rd_addr = ADDR_W'({r_inst, n_slot});

    // sequencer
    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_ok    = r_ok;
        n_err   = r_err;
        n_level = r_level;
        n_null  = r_null;
        n_alen  = r_alen;
        n_last  = r_last;
        wr_en   = 1'b0;
        wr_data = LEVEL_NULL;
        oos_we  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // default: single status beat
                n_state = S_OUT;
                n_level = '0;
                n_null  = 1'b0;
                n_alen  = '0;
                n_last  = 1'b1;
                n_err   = ERR_NONE;
                if (r_cmd > CMD_READ_ALL) begin
                    n_err = ERR_DENIED;
                end else if (!r_inst_ok) begin
                    n_err = ERR_UNKNOWN;
                end else begin
                    case (r_cmd)
                        CMD_WRITE_VALUE: begin
                            if (r_tag == TAG_REAL) begin
                                if (real_ok) begin
                                    wr_en   = 1'b1;
                                    wr_data = r_val[VAL_W-1 -: LEVEL_W];
                                end else if (r_prio == RESERVED_PRIO) begin
                                    n_err = ERR_DENIED;
                                end else begin
                                    n_err = ERR_RANGE;
                                end
                            end else if (r_tag == TAG_NULL) begin
                                if (prio_ok) begin
                                    wr_en = 1'b1;
                                end else begin
                                    n_err = ERR_RANGE;
                                end
                            end else begin
                                n_err = ERR_TYPE;
                            end
                        end
                        CMD_WRITE_OOS: begin
                            if (r_tag == TAG_BOOL) begin
                                oos_we = 1'b1;
                            end else begin
                                n_err = ERR_TYPE;
                            end
                        end
                        CMD_WRITE_OTHER: begin
                            n_err = ERR_DENIED;
                        end
                        CMD_READ_PV: begin
                            n_slot  = '0;
                            n_state = S_READ;
                        end
                        CMD_READ_SLOT: begin
                            if (r_sidx == '0) begin
                                n_alen = ALEN_W'(NUM_PRIORITIES);
                            end else if (r_sidx <= SIDX_W'(NUM_PRIORITIES)) begin
                                n_slot  = SLOT_W'(r_sidx - SIDX_W'(1));
                                n_state = S_READ;
                            end else begin
                                n_err = ERR_INDEX;
                            end
                        end
                        default: begin
                            n_slot  = '0;
                            n_state = S_READ;
                        end
                    endcase
                end
                n_ok = (n_err == ERR_NONE);
            end
            S_READ: begin
                if (r_cmd == CMD_READ_PV) begin
                    // walk slots until the first non-null one
                    if (!rd_is_null) begin
                        n_level = rd_level;
                        n_state = S_OUT;
                    end else if (r_slot == SLOT_LAST) begin
                        n_level = r_relinq;
                        n_state = S_OUT;
                    end else begin
                        n_slot = r_slot + SLOT_W'(1);
                    end
                end else begin
                    n_level = rd_is_null ? '0 : rd_level;
                    n_null  = rd_is_null;
                    n_last  = (r_cmd == CMD_READ_SLOT) || (r_slot == SLOT_LAST);
                    n_state = S_OUT;
                end
            end
            default: begin
                // S_OUT: hold the beat until taken
                if (o_rsp.ready) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_slot  = r_slot + SLOT_W'(1);
                        n_state = S_READ;
                    end
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_slot    <= '0;
            r_relinq  <= '0;
            r_oos     <= '0;
            r_mem_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_rd_vld <= r_mem_vld[rd_addr];
            if (i_cfg_we) begin
                r_relinq <= i_cfg_wdata;
            end
            if (wr_en) begin
                r_mem_vld[wr_addr] <= 1'b1;
            end
            if (oos_we) begin
                r_oos[r_inst] <= r_bv;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_req.cmd;
            r_inst_ok <= (i_req.instance_req < REQI_W'(NUM_OUTPUTS));
            r_inst    <= INST_W'(i_req.instance_req);
            r_prio    <= i_req.prio;
            r_val     <= i_req.value_q8;
            r_tag     <= i_req.tag;
            r_bv      <= i_req.bool_value;
            r_sidx    <= i_req.slot_index;
        end
        r_ok    <= n_ok;
        r_err   <= n_err;
        r_level <= n_level;
        r_null  <= n_null;
        r_alen  <= n_alen;
        r_last  <= n_last;
    end

    // slot memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign o_rsp.valid        = (r_state == S_OUT);
    assign o_rsp.ok           = r_ok;
    assign o_rsp.err          = r_err;
    assign o_rsp.level        = r_level;
    assign o_rsp.is_null      = r_null;
    assign o_rsp.array_length = r_alen;
    assign o_rsp.last         = r_last;

`ifndef SYNTHESIS
    // never take a request while a result beat is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid))
        else $error("request accepted while result pending");

    // ok and error code agree
    a_ok_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.ok == (o_rsp.err == ERR_NONE)))
        else $error("ok and err disagree");

    // a null slot reports level zero
    a_null_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.is_null) |-> (o_rsp.level == '0))
        else $error("null slot with nonzero level");

    // read-all marks only the final slot
    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && r_inst_ok && r_cmd == CMD_READ_ALL)
        |-> (o_rsp.last == (r_slot == SLOT_LAST)))
        else $error("read-all last mark misplaced");

    // successful out-of-service write lands in the flag
    a_oos_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ok && r_cmd == CMD_WRITE_OOS) |-> (r_oos[r_inst] == r_bv))
        else $error("out-of-service flag not updated");
`endif

endmodule

`default_nettype wire

// ===== sim/pca_checker.sv =====
// Scoreboard for the command priority array: watches the request, response and
// configuration ports, predicts every response beat and compares field by field.
// Depends on pca_pkg and the channel interfaces in pca_ifs.sv.

module pca_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pca_req_if                          i_req,
    pca_rsp_if                          i_rsp,
    input  logic                        i_cfg_we,
    input  logic [pca_pkg::LEVEL_W-1:0] i_cfg_wdata,
    output int                          o_mismatches,
    output int                          o_pending,
    output int                          o_beats_seen
);
    import pca_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic               ok;
        logic [ERR_W-1:0]   err;
        logic [LEVEL_W-1:0] level;
        logic               is_null;
        logic [ALEN_W-1:0]  alen;
        logic               last;
    } rsp_beat_t;

    // predicted beats, oldest first
    rsp_beat_t          expected_beats [$];

    // shadow of the block state
    logic [LEVEL_W-1:0] slot_level [NUM_OUTPUTS][NUM_PRIORITIES];
    logic               oos_flag   [NUM_OUTPUTS];
    logic [LEVEL_W-1:0] default_level;

    task automatic push_beat(input logic ok, input logic [ERR_W-1:0] err,
                             input logic [LEVEL_W-1:0] level, input logic is_null,
                             input logic [ALEN_W-1:0] alen, input logic last);
        rsp_beat_t b;
        b.ok      = ok;
        b.err     = err;
        b.level   = level;
        b.is_null = is_null;
        b.alen    = alen;
        b.last    = last;
        expected_beats.push_back(b);
    endtask

    task automatic push_status(input logic [ERR_W-1:0] code);
        push_beat(code == ERR_NONE, code, '0, 1'b0, '0, 1'b1);
    endtask

    // Work out the beats one accepted command produces and update the shadow.
    task automatic predict_command();
        logic [CMD_W-1:0]   cmd;
        logic [REQI_W-1:0]  inst;
        logic [PRIO_W-1:0]  prio;
        logic [VAL_W-1:0]   raw;
        logic [TAG_W-1:0]   tag;
        logic [SIDX_W-1:0]  sidx;
        logic               prio_ok;
        logic               in_range;
        logic [LEVEL_W-1:0] lv;
        logic [LEVEL_W-1:0] pv;
        int                 o;
        cmd  = i_req.cmd;
        inst = i_req.instance_req;
        prio = i_req.prio;
        raw  = i_req.value_q8;
        tag  = i_req.tag;
        sidx = i_req.slot_index;
        o    = int'(inst[INST_W-1:0]);

        if (cmd > CMD_READ_ALL) begin
            push_status(ERR_DENIED);
        end else if (inst >= NUM_OUTPUTS) begin
            push_status(ERR_UNKNOWN);
        end else begin
            case (cmd)
                CMD_WRITE_VALUE: begin
                    if (tag == TAG_REAL) begin
                        prio_ok  = prio >= 1 && prio <= NUM_PRIORITIES && prio != RESERVED_PRIO;
                        // 0 to 100.0 in q8; sign bit set means negative
                        in_range = !raw[VAL_W-1] && raw <= MAX_VALUE_Q8;
                        if (prio_ok && in_range) begin
                            slot_level[o][int'(prio) - 1] = raw[VAL_W-1:8];
                            push_status(ERR_NONE);
                        end else if (prio == RESERVED_PRIO) begin
                            push_status(ERR_DENIED);
                        end else begin
                            push_status(ERR_RANGE);
                        end
                    end else if (tag == TAG_NULL) begin
                        if (prio >= 1 && prio <= NUM_PRIORITIES) begin
                            slot_level[o][int'(prio) - 1] = LEVEL_NULL;
                            push_status(ERR_NONE);
                        end else begin
                            push_status(ERR_RANGE);
                        end
                    end else begin
                        push_status(ERR_TYPE);
                    end
                end
                CMD_WRITE_OOS: begin
                    if (tag == TAG_BOOL) begin
                        oos_flag[o] = i_req.bool_value;
                        push_status(ERR_NONE);
                    end else begin
                        push_status(ERR_TYPE);
                    end
                end
                CMD_WRITE_OTHER: begin
                    push_status(ERR_DENIED);
                end
                CMD_READ_PV: begin
                    // first non-null slot wins, else the relinquish default
                    pv = default_level;
                    for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
                        if (slot_level[o][i] != LEVEL_NULL)
                            pv = slot_level[o][i];
                    end
                    push_beat(1'b1, ERR_NONE, pv, 1'b0, '0, 1'b1);
                end
                CMD_READ_SLOT: begin
                    if (sidx == 0) begin
                        push_beat(1'b1, ERR_NONE, '0, 1'b0, ALEN_W'(NUM_PRIORITIES), 1'b1);
                    end else if (sidx <= NUM_PRIORITIES) begin
                        lv = slot_level[o][int'(sidx) - 1];
                        push_beat(1'b1, ERR_NONE, (lv == LEVEL_NULL) ? '0 : lv,
                                  lv == LEVEL_NULL, '0, 1'b1);
                    end else begin
                        push_status(ERR_INDEX);
                    end
                end
                default: begin
                    // read all: one beat per slot, last on the final one
                    for (int i = 0; i < NUM_PRIORITIES; i++) begin
                        lv = slot_level[o][i];
                        push_beat(1'b1, ERR_NONE, (lv == LEVEL_NULL) ? '0 : lv,
                                  lv == LEVEL_NULL, '0, i == NUM_PRIORITIES - 1);
                    end
                end
            endcase
        end
    endtask

    // Compare one response beat with the oldest prediction.
    task automatic check_beat();
        rsp_beat_t got;
        rsp_beat_t want;
        got.ok      = i_rsp.ok;
        got.err     = i_rsp.err;
        got.level   = i_rsp.level;
        got.is_null = i_rsp.is_null;
        got.alen    = i_rsp.array_length;
        got.last    = i_rsp.last;
        o_beats_seen++;
        if (expected_beats.size() == 0) begin
            o_mismatches++;
            if (o_mismatches <= REPORT_LIMIT)
                $display("%0t: response beat with nothing expected: ok=%0d err=%0d level=%0d",
                         $time, got.ok, got.err, got.level);
        end else begin
            want = expected_beats.pop_front();
            if (got != want) begin
                o_mismatches++;
                if (o_mismatches <= REPORT_LIMIT)
                    $display("%0t: mismatch, expected ok=%0d err=%0d level=%0d null=%0d ",
                             $time, want.ok, want.err, want.level, want.is_null,
                             "len=%0d last=%0d, got ok=%0d err=%0d level=%0d null=%0d ",
                             want.alen, want.last, got.ok, got.err, got.level, got.is_null,
                             "len=%0d last=%0d", got.alen, got.last);
            end
        end
    endtask

    // Sample all ports at the rising edge; responses first, then config, then requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int o = 0; o < NUM_OUTPUTS; o++) begin
                oos_flag[o] = 1'b0;
                for (int i = 0; i < NUM_PRIORITIES; i++)
                    slot_level[o][i] = LEVEL_NULL;
            end
            default_level = '0;
            expected_beats.delete();
            o_mismatches = 0;
            o_beats_seen = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready)
                check_beat();
            if (i_cfg_we)
                default_level = i_cfg_wdata;
            if (i_req.valid && i_req.ready)
                predict_command();
        end
        o_pending = expected_beats.size();
    end

endmodule

// ===== sim/tb_priority_command_array.sv =====
// Testbench top for priority_command_array: clock, reset, request stimulus,
// response pacing and the verdict. Depends on pca_pkg, pca_ifs.sv and pca_checker.

module tb_priority_command_array;
    import pca_pkg::*;

    localparam int CYCLE_LIMIT     = 800000;
    localparam int HOLD_CYCLES     = 400;
    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 68;
    localparam int DRAIN_CYCLES    = 40;

    // codes the package leaves unnamed
    localparam logic [TAG_W-1:0] TAG_OTHER   = 2'd3;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [REQI_W-1:0] instance_req;
        logic [PRIO_W-1:0] prio;
        logic [VAL_W-1:0]  value_q8;
        logic [TAG_W-1:0]  tag;
        logic              bool_value;
        logic [SIDX_W-1:0] slot_index;
    } command_t;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [LEVEL_W-1:0] cfg_wdata = '0;
    logic               hold_go   = 1'b0;
    int                 cycle_count = 0;
    int                 items_sent  = 0;
    int                 mismatches;
    int                 pending;
    int                 beats_seen;

    pca_req_if req_ch ();
    pca_rsp_if rsp_ch ();

    priority_command_array dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    pca_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_beats_seen (beats_seen)
    );

    always #5 i_clk = ~i_clk;

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats still expected", cycle_count, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one command and hold it until the beat is taken; returns at a falling edge.
    task automatic send_command(input command_t c);
        req_ch.cmd          <= c.cmd;
        req_ch.instance_req <= c.instance_req;
        req_ch.prio         <= c.prio;
        req_ch.value_q8     <= c.value_q8;
        req_ch.tag          <= c.tag;
        req_ch.bool_value   <= c.bool_value;
        req_ch.slot_index   <= c.slot_index;
        req_ch.valid        <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            req_ch.valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [REQI_W-1:0] inst,
                         input logic [PRIO_W-1:0] prio, input logic [VAL_W-1:0] val,
                         input logic [TAG_W-1:0] tag, input logic bv,
                         input logic [SIDX_W-1:0] sidx);
        command_t c;
        c.cmd          = cmd;
        c.instance_req = inst;
        c.prio         = prio;
        c.value_q8     = val;
        c.tag          = tag;
        c.bool_value   = bv;
        c.slot_index   = sidx;
        send_command(c);
    endtask

    // Stop offering and wait until every predicted beat has come back.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_default(input logic [LEVEL_W-1:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly well-formed commands on real outputs; the rest exercise the error paths.
    function automatic command_t random_command();
        command_t c;
        int       pick;
        c.cmd          = CMD_READ_PV;
        c.instance_req = REQI_W'($urandom);
        c.prio         = PRIO_W'($urandom);
        c.value_q8     = VAL_W'($urandom);
        c.tag          = TAG_W'($urandom);
        c.bool_value   = 1'($urandom);
        c.slot_index   = SIDX_W'($urandom);
        if ($urandom_range(0, 9) != 0)
            c.instance_req = REQI_W'($urandom_range(0, NUM_OUTPUTS - 1));
        else if ($urandom_range(0, 1) == 0)
            c.instance_req = REQI_W'($urandom_range(NUM_OUTPUTS, 2 * NUM_OUTPUTS));
        pick = $urandom_range(0, 99);
        if (pick < 32) begin
            c.cmd = CMD_WRITE_VALUE;
            pick  = $urandom_range(0, 99);
            if (pick < 60)      c.tag = TAG_REAL;
            else if (pick < 88) c.tag = TAG_NULL;
            else if (pick < 94) c.tag = TAG_BOOL;
            else                c.tag = TAG_OTHER;
            if ($urandom_range(0, 9) != 0)
                c.prio = PRIO_W'($urandom_range(1, NUM_PRIORITIES));
            if ($urandom_range(0, 6) != 0)
                c.value_q8 = VAL_W'($urandom_range(0, MAX_VALUE_Q8));
        end else if (pick < 40) begin
            c.cmd = CMD_WRITE_OOS;
            if ($urandom_range(0, 6) != 0)
                c.tag = TAG_BOOL;
        end else if (pick < 43) begin
            c.cmd = CMD_WRITE_OTHER;
        end else if (pick < 60) begin
            c.cmd = CMD_READ_PV;
        end else if (pick < 82) begin
            c.cmd = CMD_READ_SLOT;
            if ($urandom_range(0, 6) != 0)
                c.slot_index = SIDX_W'($urandom_range(0, NUM_PRIORITIES));
        end else if (pick < 95) begin
            c.cmd = CMD_READ_ALL;
        end else begin
            c.cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
        end
        return c;
    endfunction

    // Response side: random stall patterns, plus one long hold-off on request.
    initial begin : response_pacing
        int   mode;
        int   mode_left;
        int   stall_left;
        int   hold_left;
        int   tick;
        logic hold_done;
        rsp_ch.ready = 1'b0;
        mode       = 0;
        mode_left  = 0;
        stall_left = 0;
        hold_left  = HOLD_CYCLES;
        tick       = 0;
        hold_done  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_done) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
                if (hold_left == 0)
                    hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                tick++;
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            rsp_ch.ready <= 1'b0;
                        end else if ($urandom_range(0, 7) == 0) begin
                            stall_left = $urandom_range(1, 30);
                            rsp_ch.ready <= 1'b0;
                        end else begin
                            rsp_ch.ready <= 1'b1;
                        end
                    end
                    default: rsp_ch.ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // Request side: reset, directed checks, then random phases under several defaults.
    initial begin : stimulus
        int                 n;
        int                 burst;
        int                 gap;
        logic [LEVEL_W-1:0] phase_default [RANDOM_PHASES];
        req_ch.valid        = 1'b0;
        req_ch.cmd          = '0;
        req_ch.instance_req = '0;
        req_ch.prio         = '0;
        req_ch.value_q8     = '0;
        req_ch.tag          = '0;
        req_ch.bool_value   = 1'b0;
        req_ch.slot_index   = '0;
        phase_default[0] = 8'd255;
        phase_default[1] = LEVEL_W'($urandom);
        phase_default[2] = 8'd0;
        phase_default[3] = 8'd100;
        phase_default[4] = LEVEL_W'($urandom);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);
        write_default(8'd200);

        // all slots null: present value falls back to the default
        issue(CMD_READ_PV, 22'd1, 8'd0, 16'd0, TAG_REAL, 1'b0, 8'd0);
        // real writes at the edges of the value range, and truncation
        issue(CMD_WRITE_VALUE, 22'd0, 8'd1, 16'd0, TAG_REAL, 1'b0, 8'd0);
        issue(CMD_WRITE_VALUE, 22'd3, 8'd16, MAX_VALUE_Q8, TAG_REAL, 1'b0, 8'd0);
        issue(CMD_WRITE_VALUE, 22'd3, 8'd8, 16'h63FF, TAG_REAL, 1'b0, 8'd0);
        issue(CMD_WRITE_VALUE, 22'd0, 8'd2, 16'd25601, TAG_REAL, 1'b0, 8'd0);
        issue(CMD_WRITE_VALUE, 22'd0, 8'd2, 16'hFFFF, TAG_REAL, 1'b0, 8'd0);
        issue(CMD_WRITE_VALUE, 22'd0, 8'd2, 16'h7FFF, TAG_REAL, 1'b0, 8'd0);
        // reserved and out-of-range priorities
        issue(CMD_WRITE_VALUE, 22'd0, RESERVED_PRIO, 16'd512, TAG_REAL, 1'b0, 8'd0);
        issue(CMD_WRITE_VALUE, 22'd0, 8'd0, 16'd512, TAG_REAL, 1'b0, 8'd0);
        issue(CMD_WRITE_VALUE, 22'd0, 8'd255, 16'd512, TAG_REAL, 1'b0, 8'd0);
        // null writes relinquish, the reserved priority included
        issue(CMD_WRITE_VALUE, 22'd0, RESERVED_PRIO, 16'd0, TAG_NULL, 1'b0, 8'd0);
        issue(CMD_WRITE_VALUE, 22'd0, 8'd17, 16'd0, TAG_NULL, 1'b0, 8'd0);
        // wrong value types
        issue(CMD_WRITE_VALUE, 22'd1, 8'd3, 16'd256, TAG_BOOL, 1'b1, 8'd0);
        issue(CMD_WRITE_VALUE, 22'd1, 8'd3, 16'd256, TAG_OTHER, 1'b0, 8'd0);
        issue(CMD_WRITE_OOS, 22'd2, 8'd0, 16'd0, TAG_BOOL, 1'b1, 8'd0);
        issue(CMD_WRITE_OOS, 22'd2, 8'd0, 16'd0, TAG_REAL, 1'b0, 8'd0);
        // refused and unused commands, unknown objects
        issue(CMD_WRITE_OTHER, 22'd1, 8'd1, 16'd0, TAG_REAL, 1'b0, 8'd0);
        issue(CMD_SPARE_6, 22'd0, 8'd1, 16'd0, TAG_REAL, 1'b0, 8'd0);
        issue(CMD_SPARE_7, 22'd0, 8'd1, 16'd0, TAG_REAL, 1'b0, 8'd0);
        issue(CMD_READ_PV, 22'd4, 8'd0, 16'd0, TAG_REAL, 1'b0, 8'd0);
        issue(CMD_WRITE_VALUE, 22'h3FFFFF, 8'd1, 16'd0, TAG_REAL, 1'b0, 8'd0);
        // reads: present value, length, slot edges, bad index, whole array
        issue(CMD_READ_PV, 22'd3, 8'd0, 16'd0, TAG_REAL, 1'b0, 8'd0);
        issue(CMD_READ_SLOT, 22'd0, 8'd0, 16'd0, TAG_REAL, 1'b0, 8'd0);
        issue(CMD_READ_SLOT, 22'd0, 8'd0, 16'd0, TAG_REAL, 1'b0, 8'd1);
        issue(CMD_READ_SLOT, 22'd3, 8'd0, 16'd0, TAG_REAL, 1'b0, 8'd16);
        issue(CMD_READ_SLOT, 22'd0, 8'd0, 16'd0, TAG_REAL, 1'b0, 8'd17);
        issue(CMD_READ_SLOT, 22'd0, 8'd0, 16'd0, TAG_REAL, 1'b0, 8'd255);
        issue(CMD_READ_ALL, 22'd3, 8'd0, 16'd0, TAG_REAL, 1'b0, 8'd0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_default(phase_default[phase]);
            // first phase: response side holds off while requests keep coming
            if (phase == 0)
                hold_go <= 1'b1;
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                burst = $urandom_range(1, 8);
                for (int k = 0; k < burst && n < ITEMS_PER_PHASE; k++) begin
                    send_command(random_command());
                    n++;
                end
                // phase 2 runs back to back with no sender gaps
                gap = (phase == 2) ? 0 : $urandom_range(0, 6);
                pause_sender(gap);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Sent %0d commands under %0d relinquish defaults; %0d response beats checked.",
                 items_sent, RANDOM_PHASES + 1, beats_seen);
        $display("Mismatches counted: %0d", mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/pca_pkg.sv
src/pca_ifs.sv
src/priority_command_array.sv
sim/pca_checker.sv
sim/tb_priority_command_array.sv
